@@ rtl/srnt_pkg.sv @@
package srnt_pkg;

  localparam int REORDER_WINDOW = 32;
  localparam int IDX_W          = $clog2(REORDER_WINDOW);
  localparam int SEQ_W          = 32;
  localparam int ACT_W          = 2;
  localparam int KIND_W         = 4;
  localparam int NACK_W         = 5;
  localparam int GROUP_SIZE     = 8;
  localparam int GROUPS         = (REORDER_WINDOW + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PART_W         = $clog2(GROUP_SIZE + 1);

  typedef logic [SEQ_W-1:0]          seq_t;
  typedef logic [REORDER_WINDOW-1:0] window_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [NACK_W-1:0]         nack_cnt_t;
  typedef logic [PART_W-1:0]         part_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_HEADER = 2'd0,
    ACT_TIMER  = 2'd1,
    ACT_SENT   = 2'd2
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    K_DELIVER   = 4'd0,
    K_ARM       = 4'd1,
    K_CANCEL    = 4'd2,
    K_SYN_REPLY = 4'd3,
    K_ACK       = 4'd4,
    K_NACK      = 4'd5,
    K_CLOSE     = 4'd6,
    K_RESET     = 4'd7,
    K_DROP      = 4'd8,
    K_NO_ACK    = 4'd9
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic  take;
    logic  first;
    logic  deliver;
    logic  save_gap;
    logic  set_pending;
    logic  clr_pending;
    logic  scan_load;
    logic  scan_sum;
    logic  scan_total;
    logic  nack_step;
    logic  emit;
    kind_t emit_kind;
    logic  emit_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic seq_zero;
    logic syn;
    logic open;
    logic any_received;
    logic ack_pending;
    logic is_next;
    logic is_dup;
    logic in_window;
    logic deliver_cls;
    logic rebased0;
    logic count_zero;
    logic nack_single;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/srnt_in_if.sv @@
interface srnt_in_if;
  import srnt_pkg::*;

  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  seq_t             seq_number;
  logic             syn_flag;
  logic             close_flag;
  logic             stream_open;

  modport source (
    output valid, action, seq_number, syn_flag, close_flag, stream_open,
    input  ready
  );

  modport sink (
    input  valid, action, seq_number, syn_flag, close_flag, stream_open,
    output ready
  );

endinterface

@@ rtl/srnt_out_if.sv @@
interface srnt_out_if;
  import srnt_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  seq_t              seq_value;
  nack_cnt_t         nack_total;
  logic              last_of_run;

  modport source (
    output valid, kind, seq_value, nack_total, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, kind, seq_value, nack_total, last_of_run,
    output ready
  );

endinterface

@@ rtl/srnt_dp.sv @@
module srnt_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  srnt_pkg::cmd_t             cmd,
  output srnt_pkg::sts_t             sts,
  input  logic [srnt_pkg::ACT_W-1:0] action,
  input  srnt_pkg::seq_t             seq_number,
  input  logic                       syn_flag,
  input  logic                       close_flag,
  input  logic                       stream_open,
  input  logic                       out_ready,
  output logic                       out_valid,
  output srnt_pkg::kind_t            kind,
  output srnt_pkg::seq_t             seq_value,
  output srnt_pkg::nack_cnt_t        nack_total,
  output logic                       last_of_run
);
  import srnt_pkg::*;

  localparam seq_t WIN_SEQ = SEQ_W'(REORDER_WINDOW);

  function automatic idx_t msb_index(window_t v);
    idx_t r;
    r = '0;
    for (int i = 0; i < REORDER_WINDOW; i++) begin
      if (v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

  function automatic idx_t lsb_index(window_t v);
    idx_t r;
    r = '0;
    for (int i = REORDER_WINDOW - 1; i >= 0; i--) begin
      if (v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

  // latched item
  logic [ACT_W-1:0] item_action;
  seq_t             item_seq;
  logic             item_syn;
  logic             item_cls;
  logic             item_open;

  // tracker state
  logic    any_received;
  seq_t    last_in_order;
  logic    ack_pending;
  window_t saved_bitmap;
  window_t saved_close;

  // quick ack scan
  idx_t      hi_idx;
  window_t   nack_mask;
  part_t     part_cnt [GROUPS];
  nack_cnt_t nack_count;

  seq_t    next_seq;
  seq_t    offset;
  idx_t    off_idx;
  seq_t    deliver_seq;
  logic    deliver_cls;
  seq_t    new_next;
  seq_t    down;
  seq_t    up;
  window_t rebased_map;
  window_t rebased_cls;
  idx_t    hi_now;
  window_t low_mask;
  logic [GROUPS*GROUP_SIZE-1:0] padded_mask;
  part_t     part_next [GROUPS];
  nack_cnt_t total_next;
  idx_t    nack_idx;
  seq_t    nack_seq;
  seq_t    ack_seq;
  seq_t    emit_seq;
  logic    out_free;

  assign next_seq    = any_received ? last_in_order + 1'b1 : '0;
  assign offset      = item_seq - next_seq;
  assign off_idx     = offset[IDX_W-1:0];
  assign deliver_seq = cmd.first ? item_seq : last_in_order + 1'b1;
  assign deliver_cls = cmd.first ? item_cls : saved_close[0];
  assign new_next    = deliver_seq + 1'b1;
  assign out_free    = !out_valid || out_ready;

  // move the bitmap so that bit 0 is the new expected number
  always_comb begin
    down = next_seq - new_next;
    up   = new_next - next_seq;
    if (down < WIN_SEQ) begin
      rebased_map = saved_bitmap << down[IDX_W-1:0];
      rebased_cls = saved_close << down[IDX_W-1:0];
    end else if (up < WIN_SEQ) begin
      rebased_map = saved_bitmap >> up[IDX_W-1:0];
      rebased_cls = saved_close >> up[IDX_W-1:0];
    end else begin
      rebased_map = '0;
      rebased_cls = '0;
    end
  end

  // holes below the highest saved entry
  always_comb begin
    hi_now = msb_index(saved_bitmap);
    for (int j = 0; j < REORDER_WINDOW; j++) begin
      low_mask[j] = (IDX_W'(j) < hi_now);
    end
  end

  always_comb begin
    padded_mask = '0;
    padded_mask[REORDER_WINDOW-1:0] = nack_mask;
    for (int g = 0; g < GROUPS; g++) begin
      part_next[g] = '0;
      for (int b = 0; b < GROUP_SIZE; b++) begin
        part_next[g] = part_next[g] + PART_W'(padded_mask[g*GROUP_SIZE+b]);
      end
    end
    total_next = '0;
    for (int g = 0; g < GROUPS; g++) begin
      total_next = total_next + NACK_W'(part_cnt[g]);
    end
  end

  assign nack_idx = lsb_index(nack_mask);
  assign nack_seq = last_in_order + 1'b1 + SEQ_W'(nack_idx);
  assign ack_seq  = (hi_idx != '0) ? last_in_order + 1'b1 + SEQ_W'(hi_idx) : last_in_order;

  always_comb begin
    unique case (cmd.emit_kind)
      K_DELIVER: emit_seq = deliver_seq;
      K_ACK:     emit_seq = ack_seq;
      K_NACK:    emit_seq = nack_seq;
      K_DROP:    emit_seq = item_seq;
      default:   emit_seq = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      any_received  <= 1'b0;
      last_in_order <= '0;
      ack_pending   <= 1'b0;
      saved_bitmap  <= '0;
      saved_close   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.deliver) begin
        last_in_order <= deliver_seq;
        any_received  <= 1'b1;
        saved_bitmap  <= rebased_map;
        saved_close   <= rebased_cls;
      end else if (cmd.save_gap && !saved_bitmap[off_idx]) begin
        saved_bitmap[off_idx] <= 1'b1;
        saved_close[off_idx]  <= item_cls;
      end
      if (cmd.set_pending) begin
        ack_pending <= 1'b1;
      end else if (cmd.clr_pending) begin
        ack_pending <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_action <= action;
      item_seq    <= seq_number;
      item_syn    <= syn_flag;
      item_cls    <= close_flag;
      item_open   <= stream_open;
    end
    if (cmd.scan_load) begin
      hi_idx    <= hi_now;
      nack_mask <= ~saved_bitmap & low_mask;
    end else if (cmd.nack_step) begin
      nack_mask[nack_idx] <= 1'b0;
    end
    if (cmd.scan_sum) begin
      part_cnt <= part_next;
    end
    if (cmd.scan_total) begin
      nack_count <= total_next;
    end
    if (cmd.emit) begin
      kind        <= cmd.emit_kind;
      seq_value   <= emit_seq;
      nack_total  <= (cmd.emit_kind == K_ACK) ? nack_count : '0;
      last_of_run <= cmd.emit_last;
    end
  end

  always_comb begin
    sts.action       = item_action;
    sts.seq_zero     = (item_seq == '0);
    sts.syn          = item_syn;
    sts.open         = item_open;
    sts.any_received = any_received;
    sts.ack_pending  = ack_pending;
    sts.is_next      = any_received && (item_seq == next_seq);
    sts.is_dup       = any_received && (item_seq <= last_in_order);
    sts.in_window    = (offset < WIN_SEQ);
    sts.deliver_cls  = deliver_cls;
    sts.rebased0     = rebased_map[0];
    sts.count_zero   = (nack_count == '0);
    sts.nack_single  = ((nack_mask & (nack_mask - 1'b1)) == '0);
    sts.out_free     = out_free;
  end

endmodule

@@ rtl/srnt_ctrl.sv @@
module srnt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output srnt_pkg::cmd_t cmd,
  input  srnt_pkg::sts_t sts
);
  import srnt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DELIVER,
    S_CLOSE,
    S_ARM,
    S_SYN_REPLY,
    S_DROP,
    S_CANCEL,
    S_RESET,
    S_NO_ACK,
    S_QA_LOAD,
    S_QA_SUM,
    S_QA_TOTAL,
    S_ACK,
    S_NACK
  } state_t;

  state_t state;
  state_t state_next;
  logic   first;
  logic   first_next;
  logic   post_arm;
  logic   post_syn;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      first <= 1'b0;
    end else begin
      state <= state_next;
      first <= first_next;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign post_arm = sts.open && !sts.ack_pending;
  assign post_syn = !sts.open && sts.syn;

  always_comb begin
    cmd        = '0;
    cmd.first  = first;
    state_next = state;
    first_next = first;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.action)
          ACT_HEADER: begin
            priority if (sts.seq_zero && !sts.syn) begin
              state_next = S_IDLE;
            end else if (sts.syn || sts.is_next) begin
              first_next = 1'b1;
              state_next = S_DELIVER;
            end else if (sts.is_dup) begin
              state_next = S_QA_LOAD;
            end else if (!sts.in_window) begin
              state_next = S_DROP;
            end else begin
              cmd.save_gap = 1'b1;
              if (!sts.any_received) begin
                state_next = S_ARM;
              end else if (sts.ack_pending) begin
                state_next = S_CANCEL;
              end else begin
                state_next = S_QA_LOAD;
              end
            end
          end
          ACT_TIMER: begin
            if (sts.ack_pending) begin
              cmd.clr_pending = 1'b1;
              if (!sts.any_received) begin
                state_next = S_RESET;
              end else if (sts.open) begin
                state_next = S_QA_LOAD;
              end else begin
                state_next = S_IDLE;
              end
            end else begin
              state_next = S_IDLE;
            end
          end
          ACT_SENT: begin
            cmd.clr_pending = 1'b1;
            state_next      = S_IDLE;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_DELIVER: begin
        if (sts.out_free) begin
          cmd.deliver   = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_kind = K_DELIVER;
          cmd.emit_last = !sts.deliver_cls && !sts.rebased0 && !post_arm && !post_syn;
          first_next    = 1'b0;
          // close stops the drain
          priority if (sts.deliver_cls) begin
            state_next = S_CLOSE;
          end else if (sts.rebased0) begin
            state_next = S_DELIVER;
          end else if (post_arm) begin
            state_next = S_ARM;
          end else if (post_syn) begin
            state_next = S_SYN_REPLY;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_CLOSE: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = K_CLOSE;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_ARM: begin
        if (sts.out_free) begin
          cmd.set_pending = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_kind   = K_ARM;
          cmd.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_SYN_REPLY: begin
        if (sts.out_free) begin
          cmd.clr_pending = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_kind   = K_SYN_REPLY;
          cmd.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_DROP: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = K_DROP;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_CANCEL: begin
        if (sts.out_free) begin
          cmd.clr_pending = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_kind   = K_CANCEL;
          cmd.emit_last   = 1'b0;
          state_next      = S_QA_LOAD;
        end
      end
      S_RESET: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = K_RESET;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_NO_ACK: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = K_NO_ACK;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_QA_LOAD: begin
        if (!sts.any_received) begin
          state_next = S_NO_ACK;
        end else begin
          cmd.scan_load = 1'b1;
          state_next    = S_QA_SUM;
        end
      end
      S_QA_SUM: begin
        cmd.scan_sum = 1'b1;
        state_next   = S_QA_TOTAL;
      end
      S_QA_TOTAL: begin
        cmd.scan_total = 1'b1;
        state_next     = S_ACK;
      end
      S_ACK: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = K_ACK;
          cmd.emit_last = sts.count_zero;
          state_next    = sts.count_zero ? S_IDLE : S_NACK;
        end
      end
      S_NACK: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = K_NACK;
          cmd.emit_last = sts.nack_single;
          cmd.nack_step = 1'b1;
          state_next    = sts.nack_single ? S_IDLE : S_NACK;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/stream_reorder_nack_tracker.sv @@
// channel   dir   payload                                              role
// items     in    action, seq_number, syn_flag, close_flag, stream_open  headers, timer, sent
// results   out   kind, seq_value, nack_total, last_of_run             actions, zero or more per item
//
// one item at a time: accept, decode, then its results in turn
// a quick ack first runs a top-bit find and a two-step hole count before its header
// at worst an item runs a cancel, the scan, the ack and a full nack walk
// rst clears the tracker state and the reorder bitmap at once, no clearing pass
// a stalled results channel holds the sequencer; an item is still taken while a
// result waits in the output register
module stream_reorder_nack_tracker (
  input logic       clk,
  input logic       rst,
  srnt_in_if.sink   items,
  srnt_out_if.source results
);
  import srnt_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign items.ready = in_ready;

  srnt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  srnt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .action      (items.action),
    .seq_number  (items.seq_number),
    .syn_flag    (items.syn_flag),
    .close_flag  (items.close_flag),
    .stream_open (items.stream_open),
    .out_ready   (results.ready),
    .out_valid   (results.valid),
    .kind        (results.kind),
    .seq_value   (results.seq_value),
    .nack_total  (results.nack_total),
    .last_of_run (results.last_of_run)
  );

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result register overwritten");

  // a state move always reports a deliver
  a_deliver_emits: assert property (@(posedge clk) disable iff (rst)
    cmd.deliver |-> (cmd.emit && cmd.emit_kind == K_DELIVER))
    else $error("deliver without result");

  // nacks only follow a nonzero count
  a_nack_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.emit_kind == K_NACK) |-> !sts.count_zero)
    else $error("nack with zero count");

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready) |=> !items.ready)
    else $error("second item taken during work");

endmodule
